// ===== design/mpa_pkg.sv =====
package mpa_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int OUT_INDEX_W = 18;
   localparam int CFG_W       = 7;
   localparam int POOL_W      = 3;
   localparam int CSR_INDEX_W = 3;

   localparam int MAX_WIDTH_DEF    = 64;
   localparam int MAX_HEIGHT_DEF   = 64;
   localparam int MAX_CHANNELS_DEF = 64;
   localparam int MAX_POOL_DEF     = 4;

   localparam logic [CFG_W-1:0]  WIDTH_RST    = 7'd28;
   localparam logic [CFG_W-1:0]  HEIGHT_RST   = 7'd28;
   localparam logic [CFG_W-1:0]  CHANNELS_RST = 7'd1;
   localparam logic [POOL_W-1:0] POOL_RST     = 3'd2;
   localparam logic [POOL_W-1:0] STRIDE_RST   = 3'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PLANE_WIDTH   = 3'd0,
      CSR_PLANE_HEIGHT  = 3'd1,
      CSR_CHANNEL_COUNT = 3'd2,
      CSR_POOL_SIZE     = 3'd3,
      CSR_STRIDE        = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] max_value;
      logic [OUT_INDEX_W-1:0]     max_index;
      logic                       last_window;
      logic                       shape_error;
   } rsp_payload_type;

   // exact for n below 128: quotients by reciprocal multiply, then a remainder check
   function automatic logic divides(input logic [CFG_W-1:0] n, input logic [POOL_W-1:0] s);
      logic [14:0]      p3;
      logic [14:0]      p5;
      logic [14:0]      p7;
      logic [CFG_W-1:0] q3;
      logic [CFG_W-1:0] q5;
      logic [CFG_W-1:0] q6;
      logic [CFG_W-1:0] q7;
      logic             ok;
      p3 = 15'(n) * 15'd171;
      p5 = 15'(n) * 15'd205;
      p7 = 15'(n) * 15'd147;
      q3 = CFG_W'(p3 >> 9);
      q5 = CFG_W'(p5 >> 10);
      q7 = CFG_W'(p7 >> 10);
      q6 = q3 >> 1;
      unique case (s)
         3'd0: ok = 1'b0;
         3'd1: ok = 1'b1;
         3'd2: ok = ~n[0];
         3'd3: ok = (n == CFG_W'(q3 * 7'd3));
         3'd4: ok = (n[1:0] == 2'd0);
         3'd5: ok = (n == CFG_W'(q5 * 7'd5));
         3'd6: ok = (n == CFG_W'(q6 * 7'd6));
         3'd7: ok = (n == CFG_W'(q7 * 7'd7));
      endcase
      return ok;
   endfunction

endpackage

// ===== design/mpa_if.sv =====
interface mpa_req_if;
   logic                     valid;
   logic                     ready;
   mpa_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mpa_rsp_if;
   logic                     valid;
   logic                     ready;
   mpa_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/mpa_line_store.sv =====
module mpa_line_store #(
   parameter int MAX_WIDTH = mpa_pkg::MAX_WIDTH_DEF,
   parameter int MAX_POOL  = mpa_pkg::MAX_POOL_DEF
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [(MAX_POOL > 1 ? $clog2(MAX_POOL) : 1)-1:0] wr_lane,
   input  logic [$clog2(MAX_WIDTH)-1:0]                 wr_addr,
   input  logic [mpa_pkg::SAMPLE_W-1:0]                 wr_data,
   input  logic                                         rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]                 rd_addr,
   output logic [MAX_POOL-1:0][mpa_pkg::SAMPLE_W-1:0]   rd_data
);

   localparam int LW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;

   for (genvar l = 0; l < MAX_POOL; l++) begin : g_lane
      logic [mpa_pkg::SAMPLE_W-1:0] mem [MAX_WIDTH];
      logic [mpa_pkg::SAMPLE_W-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (wr_en && (wr_lane == LW'(l))) begin
            mem[wr_addr] <= wr_data;
         end
         if (rd_en) begin
            rd_ff <= mem[rd_addr];
         end
      end

      assign rd_data[l] = rd_ff;
   end

endmodule

// ===== design/mpa_cell.sv =====
module mpa_cell #(
   parameter int IDX_W = mpa_pkg::OUT_INDEX_W
) (
   input  logic                                clock,
   input  logic                                shift_en,
   input  logic signed [mpa_pkg::SAMPLE_W-1:0] prev_val,
   input  logic [IDX_W-1:0]                    prev_idx,
   input  logic signed [mpa_pkg::SAMPLE_W-1:0] col_val,
   input  logic [IDX_W-1:0]                    col_idx,
   output logic signed [mpa_pkg::SAMPLE_W-1:0] next_val,
   output logic [IDX_W-1:0]                    next_idx,
   output logic signed [mpa_pkg::SAMPLE_W-1:0] hold_val,
   output logic [IDX_W-1:0]                    hold_idx
);

   logic signed [mpa_pkg::SAMPLE_W-1:0] val_ff;
   logic signed [mpa_pkg::SAMPLE_W-1:0] val_in;
   logic [IDX_W-1:0]                    idx_ff;
   logic [IDX_W-1:0]                    idx_in;
   logic                                col_wins;

   // newer column wins on a larger value, or on a tie from an earlier row
   always_comb begin
      col_wins = (col_val > prev_val) || ((col_val == prev_val) && (col_idx < prev_idx));
      val_in   = col_wins ? col_val : prev_val;
      idx_in   = col_wins ? col_idx : prev_idx;
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         val_ff <= val_in;
         idx_ff <= idx_in;
      end
   end

   assign next_val = val_in;
   assign next_idx = idx_in;
   assign hold_val = val_ff;
   assign hold_idx = idx_ff;

endmodule

// ===== design/max_pool_argmax_core.sv =====
// Path: the item completing a window is registered in stage 1 (line store read at the
// accepting edge), then column compare into stage 2, index add into stage 3 and cell chain
// into the output register; all stages hold while req_ch.ready is low.
// Throughput: one item per cycle; req_ch.ready follows the output register and rsp_ch.ready.
// Reset: synchronous; clears the position counters, error latch and stage valids and loads
// the default shape. Line store and cells keep their contents.
module max_pool_argmax_core #(
   parameter int MAX_WIDTH    = mpa_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT   = mpa_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_CHANNELS = mpa_pkg::MAX_CHANNELS_DEF,
   parameter int MAX_POOL     = mpa_pkg::MAX_POOL_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   mpa_req_if.sink                             req_ch,
   mpa_rsp_if.source                           rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [mpa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mpa_pkg::CFG_W-1:0]           csr_wr_data
);

   localparam int CFG_W    = mpa_pkg::CFG_W;
   localparam int POOL_W   = mpa_pkg::POOL_W;
   localparam int SW       = mpa_pkg::SAMPLE_W;
   localparam int XW       = $clog2(MAX_WIDTH);
   localparam int YW       = $clog2(MAX_HEIGHT);
   localparam int ZW       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int LW       = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
   localparam int IDX_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS);
   localparam int IDX_W    = (IDX_BITS > mpa_pkg::OUT_INDEX_W) ? IDX_BITS : mpa_pkg::OUT_INDEX_W;
   localparam int XCW      = ((XW > CFG_W) ? XW : CFG_W) + 1;
   localparam int YCW      = ((YW > CFG_W) ? YW : CFG_W) + 1;
   localparam int ZCW      = ((ZW > CFG_W) ? ZW : CFG_W) + 1;
   localparam int DW       = LW + CFG_W;

   logic [CFG_W-1:0]  width_ff, width_in;
   logic [CFG_W-1:0]  height_ff, height_in;
   logic [CFG_W-1:0]  chans_ff, chans_in;
   logic [POOL_W-1:0] pool_ff, pool_in;
   logic [POOL_W-1:0] stride_ff, stride_in;

   logic [XW-1:0]     col_ff, col_in;
   logic [YW-1:0]     row_ff, row_in;
   logic [ZW-1:0]     chan_ff, chan_in;
   logic [POOL_W-1:0] cx_ff, cx_in;
   logic [POOL_W-1:0] cy_ff, cy_in;
   logic [LW-1:0]     lane_ff, lane_in;
   logic [IDX_W-1:0]  base_ff, base_in;
   logic              err_ff, err_in;

   logic              adv;
   logic              accept;
   logic              first;
   logic              shape_ok;
   logic              take;
   logic              err_now;
   logic              step;
   logic [POOL_W-1:0] cx_eff;
   logic [POOL_W-1:0] cy_eff;
   logic              emit_now;
   logic              x_end;
   logic              y_end;
   logic              z_end;
   logic              restart;

   logic              s1_valid_ff, s1_err_ff, s1_emit_ff, s1_last_ff;
   logic signed [SW-1:0] s1_sample_ff;
   logic [XW-1:0]     s1_x_ff;
   logic [LW-1:0]     s1_lane_ff;
   logic [IDX_W-1:0]  s1_base_ff;
   logic [MAX_POOL-1:0][SW-1:0] rd_data;

   logic              s2_valid_ff, s2_err_ff, s2_emit_ff, s2_last_ff;
   logic signed [SW-1:0] s2_val_ff, s2_val_in;
   logic [LW-1:0]     s2_d_ff, s2_d_in;
   logic [XW-1:0]     s2_x_ff;
   logic [IDX_W-1:0]  s2_base_ff;

   logic              s3_valid_ff, s3_err_ff, s3_emit_ff, s3_last_ff;
   logic signed [SW-1:0] s3_val_ff;
   logic [IDX_W-1:0]  s3_idx_ff, s3_idx_in;
   logic [DW-1:0]     dw;

   logic signed [SW-1:0] cell_next_val [MAX_POOL];
   logic [IDX_W-1:0]     cell_next_idx [MAX_POOL];
   logic signed [SW-1:0] cell_hold_val [MAX_POOL];
   logic [IDX_W-1:0]     cell_hold_idx [MAX_POOL];
   logic                 shift_en;
   logic [LW-1:0]        pool_sel;
   logic signed [SW-1:0] res_val;
   logic [IDX_W-1:0]     res_idx;

   logic                     rsp_valid_ff, rsp_valid_in;
   mpa_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign accept       = req_ch.valid && adv;

   always_comb begin
      shape_ok = (width_ff != '0) && (int'(width_ff) <= MAX_WIDTH) &&
                 (height_ff != '0) && (int'(height_ff) <= MAX_HEIGHT) &&
                 (chans_ff != '0) && (int'(chans_ff) <= MAX_CHANNELS) &&
                 (pool_ff != '0) && (int'(pool_ff) <= MAX_POOL) &&
                 (stride_ff != '0) &&
                 (width_ff >= CFG_W'(pool_ff)) && (height_ff >= CFG_W'(pool_ff)) &&
                 mpa_pkg::divides(width_ff - CFG_W'(pool_ff), stride_ff) &&
                 mpa_pkg::divides(height_ff - CFG_W'(pool_ff), stride_ff);
   end

   always_comb begin
      first    = (col_ff == '0) && (row_ff == '0) && (chan_ff == '0);
      take     = accept && !err_ff;
      err_now  = take && first && !shape_ok;
      step     = take && !(first && !shape_ok);
      cx_eff   = (col_ff == '0) ? (pool_ff - POOL_W'(1)) : cx_ff;
      cy_eff   = (row_ff == '0) ? (pool_ff - POOL_W'(1)) : cy_ff;
      emit_now = (cx_eff == '0) && (cy_eff == '0);
      x_end    = (XCW'(col_ff) + XCW'(1)) == XCW'(width_ff);
      y_end    = (YCW'(row_ff) + YCW'(1)) == YCW'(height_ff);
      z_end    = (ZCW'(chan_ff) + ZCW'(1)) == ZCW'(chans_ff);
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      chans_in  = chans_ff;
      pool_in   = pool_ff;
      stride_in = stride_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      chan_in   = chan_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      lane_in   = lane_ff;
      base_in   = base_ff;
      err_in    = err_ff;
      restart   = 1'b0;
      if (csr_wr_en) begin
         restart = 1'b1;
         unique case (mpa_pkg::csr_index_type'(csr_index))
            mpa_pkg::CSR_PLANE_WIDTH:   width_in  = csr_wr_data;
            mpa_pkg::CSR_PLANE_HEIGHT:  height_in = csr_wr_data;
            mpa_pkg::CSR_CHANNEL_COUNT: chans_in  = csr_wr_data;
            mpa_pkg::CSR_POOL_SIZE:     pool_in   = csr_wr_data[POOL_W-1:0];
            mpa_pkg::CSR_STRIDE:        stride_in = csr_wr_data[POOL_W-1:0];
            default:                    restart   = 1'b0;
         endcase
         if (restart) begin
            col_in  = '0;
            row_in  = '0;
            chan_in = '0;
            lane_in = '0;
            base_in = '0;
            err_in  = 1'b0;
         end
      end else if (err_now) begin
         err_in = 1'b1;
      end else if (step) begin
         cx_in = (cx_eff == '0) ? (stride_ff - POOL_W'(1)) : (cx_eff - POOL_W'(1));
         if (x_end) begin
            col_in  = '0;
            cy_in   = (cy_eff == '0) ? (stride_ff - POOL_W'(1)) : (cy_eff - POOL_W'(1));
            lane_in = (lane_ff == LW'(MAX_POOL - 1)) ? '0 : (lane_ff + LW'(1));
            base_in = base_ff + IDX_W'(width_ff);
            if (y_end) begin
               row_in = '0;
               if (z_end) begin
                  chan_in = '0;
                  base_in = '0;
               end else begin
                  chan_in = chan_ff + ZW'(1);
               end
            end else begin
               row_in = row_ff + YW'(1);
            end
         end else begin
            col_in = col_ff + XW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mpa_pkg::WIDTH_RST;
         height_ff <= mpa_pkg::HEIGHT_RST;
         chans_ff  <= mpa_pkg::CHANNELS_RST;
         pool_ff   <= mpa_pkg::POOL_RST;
         stride_ff <= mpa_pkg::STRIDE_RST;
         col_ff    <= '0;
         row_ff    <= '0;
         chan_ff   <= '0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         lane_ff   <= '0;
         base_ff   <= '0;
         err_ff    <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         chans_ff  <= chans_in;
         pool_ff   <= pool_in;
         stride_ff <= stride_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         chan_ff   <= chan_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         lane_ff   <= lane_in;
         base_ff   <= base_in;
         err_ff    <= err_in;
      end
   end

   mpa_line_store #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_POOL  (MAX_POOL)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (step),
      .wr_lane (lane_ff),
      .wr_addr (col_ff),
      .wr_data (req_ch.payload.sample),
      .rd_en   (adv),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= take;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_err_ff    <= err_now;
         s1_emit_ff   <= emit_now;
         s1_last_ff   <= x_end && y_end && z_end;
         s1_sample_ff <= req_ch.payload.sample;
         s1_x_ff      <= col_ff;
         s1_lane_ff   <= lane_ff;
         s1_base_ff   <= base_ff;
      end
   end

   // column maximum over the window rows, oldest row first, strict compare
   always_comb begin
      logic                 have;
      logic signed [SW-1:0] cand;
      int                   t;
      have      = 1'b0;
      s2_val_in = s1_sample_ff;
      s2_d_in   = '0;
      for (int d = MAX_POOL - 1; d >= 0; d--) begin
         t = int'(s1_lane_ff) + MAX_POOL - d;
         if (t >= MAX_POOL) begin
            t = t - MAX_POOL;
         end
         cand = (d == 0) ? s1_sample_ff : $signed(rd_data[LW'(t)]);
         if (d < int'(pool_ff)) begin
            if (!have || (cand > s2_val_in)) begin
               s2_val_in = cand;
               s2_d_in   = LW'(d);
            end
            have = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_err_ff  <= s1_err_ff;
         s2_emit_ff <= s1_emit_ff;
         s2_last_ff <= s1_last_ff;
         s2_val_ff  <= s2_val_in;
         s2_d_ff    <= s2_d_in;
         s2_x_ff    <= s1_x_ff;
         s2_base_ff <= s1_base_ff;
      end
   end

   always_comb begin
      dw        = DW'(s2_d_ff) * DW'(width_ff);
      s3_idx_in = s2_base_ff + IDX_W'(s2_x_ff) - IDX_W'(dw);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_err_ff  <= s2_err_ff;
         s3_emit_ff <= s2_emit_ff;
         s3_last_ff <= s2_last_ff;
         s3_val_ff  <= s2_val_ff;
         s3_idx_ff  <= s3_idx_in;
      end
   end

   assign shift_en = adv && s3_valid_ff && !s3_err_ff;

   for (genvar k = 0; k < MAX_POOL; k++) begin : g_cell
      if (k == 0) begin : g_head
         mpa_cell #(.IDX_W (IDX_W)) u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .prev_val (s3_val_ff),
            .prev_idx (s3_idx_ff),
            .col_val  (s3_val_ff),
            .col_idx  (s3_idx_ff),
            .next_val (cell_next_val[k]),
            .next_idx (cell_next_idx[k]),
            .hold_val (cell_hold_val[k]),
            .hold_idx (cell_hold_idx[k])
         );
      end else begin : g_body
         mpa_cell #(.IDX_W (IDX_W)) u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .prev_val (cell_hold_val[k-1]),
            .prev_idx (cell_hold_idx[k-1]),
            .col_val  (s3_val_ff),
            .col_idx  (s3_idx_ff),
            .next_val (cell_next_val[k]),
            .next_idx (cell_next_idx[k]),
            .hold_val (cell_hold_val[k]),
            .hold_idx (cell_hold_idx[k])
         );
      end
   end

   always_comb begin
      pool_sel = LW'(pool_ff - POOL_W'(1));
      res_val  = cell_next_val[0];
      res_idx  = cell_next_idx[0];
      for (int k = 0; k < MAX_POOL; k++) begin
         if (pool_sel == LW'(k)) begin
            res_val = cell_next_val[k];
            res_idx = cell_next_idx[k];
         end
      end
   end

   always_comb begin
      rsp_valid_in = s3_valid_ff && (s3_err_ff || s3_emit_ff);
      if (s3_err_ff) begin
         rsp_payload_in.max_value   = '0;
         rsp_payload_in.max_index   = '0;
         rsp_payload_in.last_window = 1'b0;
         rsp_payload_in.shape_error = 1'b1;
      end else begin
         rsp_payload_in.max_value   = res_val;
         rsp_payload_in.max_index   = res_idx[mpa_pkg::OUT_INDEX_W-1:0];
         rsp_payload_in.last_window = s3_last_ff;
         rsp_payload_in.shape_error = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_payload_ff;

endmodule

// ===== design/mpa_checker.sv =====
module mpa_checker (
   input logic       clock,
   input logic       reset,
   mpa_rsp_if.source rsp_ch
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid)
      else $error("result dropped while stalled");

   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> $stable(rsp_ch.payload))
      else $error("result changed while stalled");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.payload.shape_error |->
         (rsp_ch.payload.max_value == '0) && (rsp_ch.payload.max_index == '0) &&
         !rsp_ch.payload.last_window)
      else $error("shape error item carries window data");

endmodule

bind max_pool_argmax_core mpa_checker u_mpa_checker (
   .clock  (clock),
   .reset  (reset),
   .rsp_ch (rsp_ch)
);

// ===== dv/tb_max_pool_argmax_core.sv =====
`timescale 1ns / 1ps

module tb_max_pool_argmax_core;

   localparam int STORE_ROWS     = mpa_pkg::MAX_POOL_DEF;
   localparam int STORE_COLS     = mpa_pkg::MAX_WIDTH_DEF;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 1725;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_wr_en;
   logic [mpa_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [mpa_pkg::CFG_W-1:0]       csr_wr_data;

   mpa_req_if req_if ();
   mpa_rsp_if rsp_if ();

   max_pool_argmax_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shape registers and stream position as the block should hold them
   int          shape_w = mpa_pkg::WIDTH_RST;
   int          shape_h = mpa_pkg::HEIGHT_RST;
   int          shape_c = mpa_pkg::CHANNELS_RST;
   int          pool_p  = mpa_pkg::POOL_RST;
   int          pool_s  = mpa_pkg::STRIDE_RST;
   int          col_pos;
   int          row_pos;
   int          chan_pos;
   bit          err_latched;
   logic [15:0] line_store [STORE_ROWS][STORE_COLS];

   logic [15:0]              sample_q [$];
   mpa_pkg::rsp_payload_type window_q [$];

   int mismatches;
   int idle_cycles;
   bit req_taken;
   int req_gap;
   int req_calm;
   int rsp_hold;
   int rsp_calm;

   task automatic flag_error(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   function automatic bit shape_valid();
      if (shape_w < 1 || shape_w > mpa_pkg::MAX_WIDTH_DEF) return 1'b0;
      if (shape_h < 1 || shape_h > mpa_pkg::MAX_HEIGHT_DEF) return 1'b0;
      if (shape_c < 1 || shape_c > mpa_pkg::MAX_CHANNELS_DEF) return 1'b0;
      if (pool_p < 1 || pool_p > mpa_pkg::MAX_POOL_DEF) return 1'b0;
      if (pool_s < 1) return 1'b0;
      if (shape_w < pool_p || shape_h < pool_p) return 1'b0;
      if ((shape_w - pool_p) % pool_s != 0) return 1'b0;
      if ((shape_h - pool_p) % pool_s != 0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void predict_window(input logic [15:0] s);
      int                       x;
      int                       y;
      int                       z;
      int                       ox;
      int                       oy;
      int                       best_idx;
      logic signed [15:0]       best;
      logic signed [15:0]       v;
      bit                       emit;
      bit                       last;
      mpa_pkg::rsp_payload_type r;
      if (err_latched) return;
      x = col_pos;
      y = row_pos;
      z = chan_pos;
      if (x == 0 && y == 0 && z == 0 && !shape_valid()) begin
         err_latched = 1'b1;
         r = '0;
         r.shape_error = 1'b1;
         window_q = {window_q, r};
         return;
      end
      line_store[y % STORE_ROWS][x] = s;
      emit = x + 1 >= pool_p && y + 1 >= pool_p &&
             (x + 1 - pool_p) % pool_s == 0 && (y + 1 - pool_p) % pool_s == 0;
      last = x + 1 == shape_w && y + 1 == shape_h && z + 1 == shape_c;
      col_pos++;
      if (col_pos >= shape_w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= shape_h) begin
            row_pos = 0;
            chan_pos++;
            if (chan_pos >= shape_c) chan_pos = 0;
         end
      end
      if (!emit) return;
      ox = x + 1 - pool_p;
      oy = y + 1 - pool_p;
      best = '0;
      best_idx = 0;
      for (int iy = 0; iy < pool_p; iy++) begin
         for (int ix = 0; ix < pool_p; ix++) begin
            v = line_store[(oy + iy) % STORE_ROWS][ox + ix];
            if ((iy == 0 && ix == 0) || v > best) begin
               best = v;
               best_idx = (ox + ix) + (oy + iy) * shape_w + z * shape_w * shape_h;
            end
         end
      end
      r.max_value   = best;
      r.max_index   = best_idx[mpa_pkg::OUT_INDEX_W-1:0];
      r.last_window = last;
      r.shape_error = 1'b0;
      window_q = {window_q, r};
   endfunction

   function automatic int next_gap(ref int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         calm = $urandom_range(30, 120);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 11))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4, 5: return 16'($urandom_range(0, 3) << 8);
         default: return 16'($urandom);
      endcase
   endfunction

   // hold the item until it is taken, then advance after an optional gap
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_if.valid <= 1'b0;
         end else if (sample_q.size() != 0) begin
            req_if.payload.sample <= sample_q.pop_front();
            req_if.valid <= 1'b1;
            req_gap = next_gap(req_calm);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_hold = next_gap(rsp_calm);
      end
   end

   always @(posedge clock) begin
      mpa_pkg::rsp_payload_type got;
      mpa_pkg::rsp_payload_type want;
      bit                       moved;
      req_taken = req_if.valid && req_if.ready;
      if (!reset) begin
         moved = req_taken;
         if (req_taken) predict_window(req_if.payload.sample);
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            got = rsp_if.payload;
            if (window_q.size() == 0) begin
               flag_error($sformatf("unexpected result %p", got));
            end else begin
               want = window_q.pop_front();
               if (got.max_value !== want.max_value)
                  flag_error($sformatf("max_value %0d, want %0d",
                                       got.max_value, want.max_value));
               if (got.max_index !== want.max_index)
                  flag_error($sformatf("max_index %0d, want %0d",
                                       got.max_index, want.max_index));
               if (got.last_window !== want.last_window)
                  flag_error($sformatf("last_window %b, want %b",
                                       got.last_window, want.last_window));
               if (got.shape_error !== want.shape_error)
                  flag_error($sformatf("shape_error %b, want %b",
                                       got.shape_error, want.shape_error));
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic write_reg(input mpa_pkg::csr_index_type idx,
                            input logic [mpa_pkg::CFG_W-1:0] val);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      case (idx)
         mpa_pkg::CSR_PLANE_WIDTH:   shape_w = val;
         mpa_pkg::CSR_PLANE_HEIGHT:  shape_h = val;
         mpa_pkg::CSR_CHANNEL_COUNT: shape_c = val;
         mpa_pkg::CSR_POOL_SIZE:     pool_p = val[mpa_pkg::POOL_W-1:0];
         mpa_pkg::CSR_STRIDE:        pool_s = val[mpa_pkg::POOL_W-1:0];
         default: ;
      endcase
      col_pos = 0;
      row_pos = 0;
      chan_pos = 0;
      err_latched = 1'b0;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_shape(input int w, input int h, input int c, input int p, input int s);
      write_reg(mpa_pkg::CSR_PLANE_WIDTH, w[mpa_pkg::CFG_W-1:0]);
      write_reg(mpa_pkg::CSR_PLANE_HEIGHT, h[mpa_pkg::CFG_W-1:0]);
      write_reg(mpa_pkg::CSR_CHANNEL_COUNT, c[mpa_pkg::CFG_W-1:0]);
      write_reg(mpa_pkg::CSR_POOL_SIZE, p[mpa_pkg::CFG_W-1:0]);
      write_reg(mpa_pkg::CSR_STRIDE, s[mpa_pkg::CFG_W-1:0]);
   endtask

   // drain all items and results, then let the pipeline empty
   task automatic settle();
      do @(posedge clock);
      while (sample_q.size() != 0 || req_if.valid || window_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int sent;
      int roll;
      int n;
      int size;
      int w;
      int h;
      int c;
      int p;
      int s;
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_index             = mpa_pkg::CSR_PLANE_WIDTH;
      csr_wr_data           = '0;
      req_if.valid          = 1'b0;
      req_if.payload.sample = '0;
      rsp_if.ready          = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // tied minimum window, tie on positive maximum
      set_shape(4, 2, 1, 2, 2);
      sample_q = '{16'h8000, 16'h8000, 16'h0000, 16'h7FFF,
                   16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF};
      settle();
      // maximum at the bottom-right corner
      set_shape(2, 2, 1, 2, 1);
      sample_q = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001};
      settle();
      // odd width does not fit stride, rest of tensor ignored
      set_shape(5, 4, 1, 2, 2);
      sample_q = '{16'h1234, 16'h7FFF, 16'h8000};
      settle();
      // one-sample windows across channels, then wrap into a new tensor
      set_shape(1, 1, 3, 1, 1);
      sample_q = '{16'h0100, 16'hFF00, 16'h7FFF, 16'h8000};
      settle();
      set_shape(4, 4, 1, 2, 0);
      sample_q = {sample_q, 16'h0001};
      settle();
      set_shape(4, 4, 1, 0, 1);
      sample_q = {sample_q, 16'h0002};
      settle();
      set_shape(0, 4, 1, 1, 1);
      sample_q = {sample_q, 16'h0003};
      settle();
      set_shape(127, 4, 1, 1, 1);
      sample_q = {sample_q, 16'h0004};
      settle();
      set_shape(4, 4, 0, 1, 1);
      sample_q = {sample_q, 16'h0005};
      settle();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            set_shape($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 7), $urandom_range(0, 7));
            n = $urandom_range(1, 4);
            sent += n;
         end else if (roll < 15) begin
            set_shape(64, 64, 64, 4, 1 << $urandom_range(0, 2));
            n = 64 * $urandom_range(4, 6);
            sent += n;
         end else begin
            p = $urandom_range(1, 4);
            s = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : $urandom_range(1, 4);
            w = p + s * $urandom_range(0, 3);
            h = p + s * $urandom_range(0, 3);
            c = $urandom_range(1, 3);
            if (w * h * c > 300) c = 1;
            set_shape(w, h, c, p, s);
            size = w * h * c;
            if ($urandom_range(0, 6) == 0) n = $urandom_range(1, size);
            else if (size < 200) n = size + $urandom_range(0, size);
            else n = size + $urandom_range(0, 2);
            sent += n;
         end
         repeat (n) sample_q = {sample_q, pick_sample()};
         settle();
      end

      settle();
      if (window_q.size() != 0)
         flag_error($sformatf("%0d results never arrived", window_q.size()));
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
